### rtl/sid_pkg.sv
// Shared types, codes and the opcode table of the SIC/XE instruction decoder.
// Used by every module of the decoder; depends on nothing else.
`default_nettype none

package sid_pkg;

  localparam int AddrBitsDefault = 20;
  localparam int OutAddrW        = 20;
  localparam int QueueDepth      = 4;

  localparam int NumOps   = 59;
  localparam int IdxW     = 6;
  localparam int DispW3   = 12;
  localparam logic [IdxW-1:0] LdbIndex = 6'd20;

  // Item kinds carried in tuser.
  localparam logic FuncSetLoc = 1'b0;
  localparam logic FuncDecode = 1'b1;

  // Instruction formats.
  localparam logic [2:0] Fmt2 = 3'd2;
  localparam logic [2:0] Fmt3 = 3'd3;
  localparam logic [2:0] Fmt4 = 3'd4;

  // Addressing modes, as the b and p bits read together.
  localparam logic [1:0] AmDirect = 2'd0;
  localparam logic [1:0] AmPc     = 2'd1;
  localparam logic [1:0] AmBase   = 2'd2;
  localparam logic [1:0] AmBoth   = 2'd3;

  // Operand modes from the n and i bits.
  localparam logic [1:0] OmSimple = 2'd0;
  localparam logic [1:0] OmImm    = 2'd1;
  localparam logic [1:0] OmInd    = 2'd2;

  localparam logic [7:0] OpTable [NumOps] = '{
    8'h18, 8'h58, 8'h90, 8'h40, 8'hB4, 8'h28,
    8'h88, 8'hA0, 8'h24, 8'h64, 8'h9C, 8'hC4,
    8'hC0, 8'hF4, 8'h3C, 8'h30, 8'h34, 8'h38,
    8'h48, 8'h00, 8'h68, 8'h50, 8'h70, 8'h08,
    8'h6C, 8'h74, 8'h04, 8'hD0, 8'h20, 8'h60,
    8'h98, 8'hC8, 8'h44, 8'hD8, 8'hAC, 8'h4C,
    8'hA4, 8'hA8, 8'hF0, 8'hEC, 8'h0C, 8'h78,
    8'h54, 8'h80, 8'hD4, 8'h14, 8'h7C, 8'hE8,
    8'h84, 8'h10, 8'h1C, 8'h5C, 8'h94, 8'hB0,
    8'hE0, 8'hF8, 8'h2C, 8'hB8, 8'hDC
  };

  localparam logic RegFmt [NumOps] = '{
    1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
    1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
    1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1, 1'b0
  };

  // Classified instruction as it travels from the front end to the back end.
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [2:0]      fmt;
    logic [3:0]      reg_first;
    logic [3:0]      reg_second;
    logic            indexed;
    logic [1:0]      addr_mode;
    logic [1:0]      operand_mode;
    logic            loads_base;
  } dec_t;

  // Position of the first table entry whose top six bits match; 0 when none does.
  function automatic logic [IdxW-1:0] find_opcode(input logic [5:0] op);
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int k = NumOps - 1; k >= 0; k--) begin
      if (OpTable[k][7:2] == op) begin
        idx = IdxW'(k);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### rtl/sicxe_instruction_decoder_core.sv
// SIC/XE instruction decoder: one decoded instruction per cycle while the result side takes beats.
// An accepted decode beat is registered in the queue: the front end classifies it and
// advances the location counter, then the back end forms the target address and updates
// the base register on the way into the output register.
// Set-location beats give no result. Reset clears the location counter and base register.
`default_nettype none

module sicxe_instruction_decoder_core #(
  parameter int ADDR_BITS = sid_pkg::AddrBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // location [19:0], code_window [51:20], zero [55:52]
  input  wire logic [55:0] s_axis_tdata_i,
  // func [0]
  input  wire logic [0:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // inst_address [19:0], mnemonic_index [25:20], format [28:26], length [31:29],
  // reg_first [35:32], reg_second [39:36], indexed [40], addr_mode [42:41],
  // operand_mode [44:43], target_address [64:45], loads_base [65], zero [71:66]
  output logic [71:0]      m_axis_tdata_o
);

  localparam int DecW   = $bits(sid_pkg::dec_t);
  localparam int EntryW = DecW + 3 * ADDR_BITS;

  sid_pkg::dec_t        f_dec, b_dec;
  logic [ADDR_BITS-1:0] f_addr, f_pc, f_disp, b_addr, b_pc, b_disp;
  logic                 f_push, q_full, q_valid, b_pop;
  logic [EntryW-1:0]    q_in, q_out;

  sid_front #(
    .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid_i),
    .ready_o     (s_axis_tready_o),
    .func_i      (s_axis_tuser_i[0]),
    .location_i  (s_axis_tdata_i[19:0]),
    .window_i    (s_axis_tdata_i[51:20]),
    .full_i      (q_full),
    .push_o      (f_push),
    .dec_o       (f_dec),
    .inst_addr_o (f_addr),
    .pc_o        (f_pc),
    .disp_o      (f_disp)
  );

  assign q_in = {f_dec, f_addr, f_pc, f_disp};

  sid_queue #(
    .WIDTH(EntryW),
    .DEPTH(sid_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign b_dec  = q_out[EntryW-1 -: DecW];
  assign b_addr = q_out[3*ADDR_BITS-1 -: ADDR_BITS];
  assign b_pc   = q_out[2*ADDR_BITS-1 -: ADDR_BITS];
  assign b_disp = q_out[ADDR_BITS-1:0];

  sid_back #(
    .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .pop_o       (b_pop),
    .dec_i       (b_dec),
    .inst_addr_i (b_addr),
    .pc_i        (b_pc),
    .disp_i      (b_disp),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .data_o      (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

### rtl/sid_front.sv
// Front end: accepts beats, keeps the location counter and classifies each instruction.
// Depends on sid_pkg.
`default_nettype none

module sid_front #(
  parameter int ADDR_BITS = sid_pkg::AddrBitsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire logic                 func_i,
  input  wire logic [19:0]          location_i,
  input  wire logic [31:0]          window_i,
  input  wire logic                 full_i,
  output logic                      push_o,
  output sid_pkg::dec_t             dec_o,
  output logic [ADDR_BITS-1:0]      inst_addr_o,
  output logic [ADDR_BITS-1:0]      pc_o,
  output logic [ADDR_BITS-1:0]      disp_o
);

  localparam int WideW = (ADDR_BITS > sid_pkg::OutAddrW) ? ADDR_BITS : sid_pkg::OutAddrW;

  logic [ADDR_BITS-1:0]     loc_d, loc_q;
  logic [7:0]               b0, b1;
  logic [sid_pkg::IdxW-1:0] idx;
  logic                     reg_fmt;
  logic [2:0]               fmt;
  logic [19:0]              field;
  logic [WideW-1:0]         field_wide, loc_wide;
  logic                     accept;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign push_o  = accept && (func_i == sid_pkg::FuncDecode);

  assign b0      = window_i[31:24];
  assign b1      = window_i[23:16];
  assign idx     = sid_pkg::find_opcode(b0[7:2]);
  assign reg_fmt = sid_pkg::RegFmt[idx];

  always_comb begin
    priority if (reg_fmt) begin
      fmt = sid_pkg::Fmt2;
    end else if (b1[4]) begin
      fmt = sid_pkg::Fmt4;
    end else begin
      fmt = sid_pkg::Fmt3;
    end
  end

  // Format 4 carries a 20-bit address, format 3 a 12-bit displacement.
  assign field      = b1[4] ? window_i[19:0] : {8'd0, window_i[19:8]};
  assign field_wide = WideW'(field);
  assign loc_wide   = WideW'(location_i);

  assign inst_addr_o = loc_q;
  assign pc_o        = loc_q + ADDR_BITS'(fmt);

  always_comb begin
    dec_o            = '0;
    dec_o.idx        = idx;
    dec_o.fmt        = fmt;
    disp_o           = '0;
    if (reg_fmt) begin
      dec_o.reg_first  = b1[7:4];
      dec_o.reg_second = b1[3:0];
    end else begin
      dec_o.indexed    = b1[7];
      dec_o.addr_mode  = b1[6:5];
      dec_o.loads_base = (idx == sid_pkg::LdbIndex);
      if (!b0[1] && b0[0]) begin
        dec_o.operand_mode = sid_pkg::OmImm;
      end else if (b0[1] && !b0[0]) begin
        dec_o.operand_mode = sid_pkg::OmInd;
      end else begin
        dec_o.operand_mode = sid_pkg::OmSimple;
      end
      // Only the PC-relative format 3 displacement is signed.
      if (b1[6:5] == sid_pkg::AmPc && !b1[4]) begin
        disp_o = {{(ADDR_BITS - sid_pkg::DispW3){window_i[19]}}, window_i[19:8]};
      end else begin
        disp_o = field_wide[ADDR_BITS-1:0];
      end
    end
  end

  always_comb begin
    loc_d = loc_q;
    if (accept) begin
      if (func_i == sid_pkg::FuncSetLoc) begin
        loc_d = loc_wide[ADDR_BITS-1:0];
      end else begin
        loc_d = pc_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_q <= '0;
    end else begin
      loc_q <= loc_d;
    end
  end

endmodule

`default_nettype wire

### rtl/sid_queue.sv
// Small first-in first-out queue between the decoder front and back ends.
// Depends on sid_pkg only for the default depth; sizes come from its parameters.
`default_nettype none

module sid_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sid_pkg::QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_d, wptr_q, rptr_d, rptr_q;
  logic [CntW-1:0]  cnt_d, cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/sid_back.sv
// Back end: forms the target address, keeps the base register and holds the result beat.
// Depends on sid_pkg.
`default_nettype none

module sid_back #(
  parameter int ADDR_BITS = sid_pkg::AddrBitsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      pop_o,
  input  wire sid_pkg::dec_t        dec_i,
  input  wire logic [ADDR_BITS-1:0] inst_addr_i,
  input  wire logic [ADDR_BITS-1:0] pc_i,
  input  wire logic [ADDR_BITS-1:0] disp_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output logic [71:0]               data_o
);

  localparam int WideW = (ADDR_BITS > sid_pkg::OutAddrW) ? ADDR_BITS : sid_pkg::OutAddrW;

  logic [ADDR_BITS-1:0] base_d, base_q, target;
  logic [WideW-1:0]     target_wide, addr_wide;
  logic                 valid_d, valid_q;
  logic [71:0]          data_d, data_q;

  // A new beat moves in whenever the output register is empty or being emptied.
  assign pop_o   = valid_i && (!valid_q || ready_i);
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    unique case (dec_i.addr_mode)
      sid_pkg::AmPc:   target = pc_i + disp_i;
      sid_pkg::AmBase: target = base_q + disp_i;
      default:         target = disp_i;
    endcase
  end

  assign target_wide = WideW'(target);
  assign addr_wide   = WideW'(inst_addr_i);

  always_comb begin
    data_d = {6'd0,
              dec_i.loads_base,
              target_wide[sid_pkg::OutAddrW-1:0],
              dec_i.operand_mode,
              dec_i.addr_mode,
              dec_i.indexed,
              dec_i.reg_second,
              dec_i.reg_first,
              dec_i.fmt,
              dec_i.fmt,
              dec_i.idx,
              addr_wide[sid_pkg::OutAddrW-1:0]};
  end

  always_comb begin
    base_d  = base_q;
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
      if (dec_i.loads_base) begin
        base_d = target;
      end
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      base_q  <= base_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

### test/sicxe_decoder_checker.sv
// Checker for the SIC/XE instruction decoder: watches both stream channels, decodes
// every accepted instruction beat on its own and compares it with the result beats.
// Depends on sid_pkg for the item kinds, formats and mode codes.
`timescale 1ns / 1ps

module sicxe_decoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [55:0] s_tdata_i,
  input  logic [0:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [71:0] m_tdata_i,
  output int          mismatch_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [19:0] inst_address;
    logic [5:0]  mnemonic_index;
    logic [2:0]  format;
    logic [2:0]  length;
    logic [3:0]  reg_first;
    logic [3:0]  reg_second;
    logic        indexed;
    logic [1:0]  addr_mode;
    logic [1:0]  operand_mode;
    logic [19:0] target_address;
    logic        loads_base;
  } decoded_t;

  // Opcodes in mnemonic order; the position of the first match is the mnemonic index.
  localparam logic [7:0] MnemonicOps [59] = '{
    8'h18, 8'h58, 8'h90, 8'h40, 8'hB4, 8'h28, 8'h88, 8'hA0, 8'h24, 8'h64,
    8'h9C, 8'hC4, 8'hC0, 8'hF4, 8'h3C, 8'h30, 8'h34, 8'h38, 8'h48, 8'h00,
    8'h68, 8'h50, 8'h70, 8'h08, 8'h6C, 8'h74, 8'h04, 8'hD0, 8'h20, 8'h60,
    8'h98, 8'hC8, 8'h44, 8'hD8, 8'hAC, 8'h4C, 8'hA4, 8'hA8, 8'hF0, 8'hEC,
    8'h0C, 8'h78, 8'h54, 8'h80, 8'hD4, 8'h14, 8'h7C, 8'hE8, 8'h84, 8'h10,
    8'h1C, 8'h5C, 8'h94, 8'hB0, 8'hE0, 8'hF8, 8'h2C, 8'hB8, 8'hDC
  };

  logic [19:0] loc_ctr   = '0;
  logic [19:0] base_reg  = '0;
  decoded_t    awaited_q[$];

  function automatic logic [5:0] mnemonic_position(input logic [7:0] op);
    logic [5:0] pos;
    logic       found;
    pos   = '0;
    found = 1'b0;
    for (int k = 0; k < 59; k++) begin
      if (!found && MnemonicOps[k][7:2] == op[7:2]) begin
        pos   = 6'(k);
        found = 1'b1;
      end
    end
    return pos;
  endfunction

  // Register-to-register opcodes; an unmatched opcode falls back to entry 0, which is not one.
  function automatic logic is_register_op(input logic [7:0] op);
    unique case ({op[7:2], 2'b00})
      8'h90, 8'hB4, 8'hA0, 8'h9C, 8'h98, 8'hAC,
      8'hA4, 8'hA8, 8'h94, 8'hB0, 8'hB8: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Decodes one window at the current location, advances the counter and, for LDB, loads the base register.
  function automatic decoded_t decode_window(input logic [31:0] win);
    decoded_t    d;
    logic [7:0]  op;
    logic [7:0]  b1;
    logic [19:0] field;
    logic [19:0] sfield;
    logic [19:0] pc;
    d  = '0;
    op = win[31:24];
    b1 = win[23:16];
    d.inst_address   = loc_ctr;
    d.mnemonic_index = mnemonic_position(op);
    if (is_register_op(op)) begin
      d.format     = sid_pkg::Fmt2;
      d.reg_first  = b1[7:4];
      d.reg_second = b1[3:0];
    end else begin
      d.indexed   = b1[7];
      d.addr_mode = b1[6:5];
      if (b1[4]) begin
        d.format = sid_pkg::Fmt4;
        field    = win[19:0];
        sfield   = field;
      end else begin
        d.format = sid_pkg::Fmt3;
        field    = {8'h00, win[19:8]};
        sfield   = {{8{win[19]}}, win[19:8]};
      end
      pc = loc_ctr + 20'(d.format);
      unique case (d.addr_mode)
        sid_pkg::AmPc:   d.target_address = pc + sfield;
        sid_pkg::AmBase: d.target_address = base_reg + field;
        default:         d.target_address = field;
      endcase
      unique case (op[1:0])
        2'b01:   d.operand_mode = sid_pkg::OmImm;
        2'b10:   d.operand_mode = sid_pkg::OmInd;
        default: d.operand_mode = sid_pkg::OmSimple;
      endcase
      if (d.mnemonic_index == sid_pkg::LdbIndex) begin
        base_reg     = d.target_address;
        d.loads_base = 1'b1;
      end
    end
    d.length = d.format;
    loc_ctr  = loc_ctr + 20'(d.format);
    return d;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatch_count_o++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : watch
    decoded_t want;
    if (!rst_ni) begin
      loc_ctr  = '0;
      base_reg = '0;
      awaited_q.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i[0] == sid_pkg::FuncSetLoc) begin
          loc_ctr = s_tdata_i[19:0];
        end else begin
          awaited_q.insert(awaited_q.size(), decode_window(s_tdata_i[51:20]));
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        if (awaited_q.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: result beat expected none, got 0x%0h", $time, m_tdata_i);
        end else begin
          want = awaited_q.pop_front();
          check_field("inst_address",   32'(want.inst_address),   32'(m_tdata_i[19:0]));
          check_field("mnemonic_index", 32'(want.mnemonic_index), 32'(m_tdata_i[25:20]));
          check_field("format",         32'(want.format),         32'(m_tdata_i[28:26]));
          check_field("length",         32'(want.length),         32'(m_tdata_i[31:29]));
          check_field("reg_first",      32'(want.reg_first),      32'(m_tdata_i[35:32]));
          check_field("reg_second",     32'(want.reg_second),     32'(m_tdata_i[39:36]));
          check_field("indexed",        32'(want.indexed),        32'(m_tdata_i[40]));
          check_field("addr_mode",      32'(want.addr_mode),      32'(m_tdata_i[42:41]));
          check_field("operand_mode",   32'(want.operand_mode),   32'(m_tdata_i[44:43]));
          check_field("target_address", 32'(want.target_address), 32'(m_tdata_i[64:45]));
          check_field("loads_base",     32'(want.loads_base),     32'(m_tdata_i[65]));
          check_field("padding",        32'd0,                    32'(m_tdata_i[71:66]));
        end
      end
    end
    pending_o = awaited_q.size();
  end

endmodule

### test/tb_sicxe_instruction_decoder_core.sv
// Top of the SIC/XE instruction decoder testbench: clock, reset, directed and random
// instruction beats, a randomly stalling result sink and the verdict.
// Depends on sid_pkg, sicxe_instruction_decoder_core and sicxe_decoder_checker.
`timescale 1ns / 1ps

module tb_sicxe_instruction_decoder_core;

  localparam int RandomItems = 950;
  localparam int StallAfter  = 200;
  localparam int StallCycles = 300;
  localparam int DrainCycles = 12;
  localparam int CycleLimit  = 200000;
  localparam logic [5:0] LdbOpTop = 6'h1A;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata  = '0;
  logic [0:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;

  int mismatches;
  int pending;
  int cycles   = 0;
  int tx_items = 0;
  int rx_beats = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sicxe_instruction_decoder_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  sicxe_decoder_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .s_tuser_i        (s_tuser),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // Idle pattern changes every 120 beats: fully random, none at all, or occasional.
  function automatic int draw_gap(input int count);
    unique case ((count / 120) % 3)
      0:       return $urandom_range(0, 12);
      1:       return 0;
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic func, input logic [19:0] loc, input logic [31:0] win);
    int gap;
    gap = draw_gap(tx_items);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {4'h0, win, loc};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tx_items++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : result_sink
    int wait_cycles;
    wait (rst_n);
    @(negedge clk);
    forever begin
      // One long hold-off lets the output side fill up and stall the input.
      wait_cycles = (rx_beats == StallAfter) ? StallCycles : draw_gap(rx_beats);
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      rx_beats++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [19:0] loc;
    logic [31:0] win;
    int          pick;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // LDB immediate from reset state, then decodes across the top of the address space.
    send_beat(sid_pkg::FuncDecode, 20'h00000, 32'h6901_2300);
    send_beat(sid_pkg::FuncSetLoc, 20'hFFFFE, 32'h0000_0000);
    send_beat(sid_pkg::FuncDecode, 20'h00000, 32'h032F_FF00);  // pc-relative, negative, wraps
    send_beat(sid_pkg::FuncDecode, 20'h00000, 32'h1B4F_FF00);  // base-relative, largest
    send_beat(sid_pkg::FuncDecode, 20'h00000, 32'h0131_2345);  // extended, pc-rel, immediate
    send_beat(sid_pkg::FuncDecode, 20'h00000, 32'h025F_FFFF);  // extended, base-rel, indirect
    send_beat(sid_pkg::FuncDecode, 20'h00000, 32'h03E8_7654);  // indexed with both b and p
    send_beat(sid_pkg::FuncDecode, 20'h00000, 32'h6B1F_FFFF);  // LDB extended, base all ones
    send_beat(sid_pkg::FuncDecode, 20'h00000, 32'h1B40_0100);  // base plus one wraps to zero
    send_beat(sid_pkg::FuncDecode, 20'h00000, 32'h9045_0000);  // register format
    send_beat(sid_pkg::FuncDecode, 20'h00000, 32'hB8FF_FFFF);  // register format, high nibbles
    send_beat(sid_pkg::FuncDecode, 20'h00000, 32'hFF10_0001);  // unmatched opcode, extended
    send_beat(sid_pkg::FuncDecode, 20'h00000, 32'h8D00_0000);  // unmatched opcode, immediate
    send_beat(sid_pkg::FuncDecode, 20'h00000, 32'h0000_0000);
    send_beat(sid_pkg::FuncDecode, 20'h00000, 32'hFFFF_FFFF);
    send_beat(sid_pkg::FuncDecode, 20'h00000, 32'h0390_0010);  // extended and indexed
    send_beat(sid_pkg::FuncDecode, 20'h00000, 32'h6A40_1000);  // LDB base-relative, indirect
    send_beat(sid_pkg::FuncSetLoc, 20'hFFFFF, 32'hFFFF_FFFF);
    send_beat(sid_pkg::FuncDecode, 20'hFFFFF, 32'h033F_FFFF);  // extended pc-relative wraps
    send_beat(sid_pkg::FuncSetLoc, 20'h00000, 32'h0000_0000);
    send_beat(sid_pkg::FuncDecode, 20'h00000, 32'h9845_0000);

    for (int n = 0; n < RandomItems; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        loc = ($urandom_range(0, 3) == 0) ? (20'hFFF00 | 20'($urandom_range(0, 255)))
                                          : 20'($urandom);
        send_beat(sid_pkg::FuncSetLoc, loc, $urandom);
      end else begin
        win = $urandom;
        if (pick >= 90) begin
          win[31:26] = LdbOpTop;
        end
        send_beat(sid_pkg::FuncDecode, 20'($urandom), win);
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
